// ----- rtl/ale_pkg.sv -----
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants of the array list engine: beat payloads,
// command and status codes, and the controller to datapath link.
// ----------------------------------------------------------------------------
package ale_pkg;

	localparam int ALE_CAPACITY   = 256;
	localparam int ALE_ELEM_WIDTH = 32;

	localparam int CMD_W   = 4;
	localparam int IDX_W   = 8;
	localparam int VAL_W   = 32;
	localparam int RES_W   = 40;
	localparam int POS_W   = 8;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND  = 4'd0,
		CMD_INSERT  = 4'd1,
		CMD_DELETE  = 4'd2,
		CMD_GET     = 4'd3,
		CMD_SET     = 4'd4,
		CMD_SEARCH  = 4'd5,
		CMD_MAX     = 4'd6,
		CMD_MIN     = 4'd7,
		CMD_SUM     = 4'd8,
		CMD_AVG     = 4'd9,
		CMD_REVERSE = 4'd10,
		CMD_ROTL    = 4'd11,
		CMD_ROTR    = 4'd12,
		CMD_SORTINS = 4'd13,
		CMD_CHECK   = 4'd14
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 3'd0,
		ST_BADIDX   = 3'd1,
		ST_FULL     = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_UNSORTED = 3'd4,
		ST_NOTFOUND = 3'd5
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		logic [POS_W-1:0]        position;
		logic [STAT_W-1:0]       status;
		logic [COUNT_W-1:0]      element_count;
		logic                    in_order;
	} out_item_t;

	typedef enum logic [5:0] {
		OP_NOP,
		OP_LOAD,
		OP_APPEND,
		OP_INS_INIT,
		OP_READ_IDX,
		OP_DEL_CAP,
		OP_DEL_FIN,
		OP_CAP_RES,
		OP_BADGET,
		OP_WRITE_IDX,
		OP_PUT_IDX,
		OP_SRCH_INIT,
		OP_SRCH_RD,
		OP_SRCH_HIT,
		OP_SRCH_UPD,
		OP_RED_INIT,
		OP_RED_STEP,
		OP_RES_BEST,
		OP_RES_ACC,
		OP_DIV_START,
		OP_RES_DIV,
		OP_SCAN_DONE,
		OP_REV_INIT,
		OP_REV_RA,
		OP_REV_RB,
		OP_REV_WA,
		OP_REV_WB,
		OP_READ0,
		OP_READ_LAST,
		OP_ROT_CAP,
		OP_PUT_TMP0,
		OP_PUT_TMP_LAST,
		OP_MV_STEP,
		OP_SI_INIT,
		OP_SI_RD,
		OP_SI_SHIFT,
		OP_SI_PUT,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    st_we;
		status_t st;
	} ctrl_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic idx_gt;
		logic idx_ge;
		logic full;
		logic empty;
		logic cnt_le1;
		logic n_zero;
		logic p_lt_q;
		logic p_zero;
		logic key_eq;
		logic key_lt;
		logic sorted;
		logic out_free;
		logic div_done;
	} dp_stat_t;

endpackage

// ----- rtl/ale_chan_if.sv -----
// ----------------------------------------------------------------------------
// ale_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ale_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ale_div.sv -----
// ----------------------------------------------------------------------------
// ale_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ale_div #(
	parameter int DW = 40,
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int SW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [SW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= SW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - SW'(1);
			if (cnt_q == SW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ----- rtl/ale_ctrl.sv -----
// ----------------------------------------------------------------------------
// ale_ctrl
// Command sequencer: decodes each beat and steps the datapath through it.
// ----------------------------------------------------------------------------
module ale_ctrl import ale_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);
	typedef enum logic [4:0] {
		S_IDLE,
		S_DEC,
		S_MOVE,
		S_MV_END,
		S_DEL,
		S_GET,
		S_ROT,
		S_SCAN,
		S_RED,
		S_RED_END,
		S_DIV,
		S_SRD,
		S_SCMP,
		S_RRA,
		S_RRB,
		S_RWA,
		S_RWB,
		S_SIRD,
		S_SICMP,
		S_FIN
	} state_t;

	state_t state_q;
	state_t nxt;

	always_comb begin
		nxt      = state_q;
		in_ready = 1'b0;
		cmd      = '{op: OP_NOP, st_we: 1'b0, st: ST_OK};
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					nxt    = S_DEC;
				end
			end
			S_DEC: begin
				nxt = S_FIN;
				unique case (stat.cmd)
					CMD_APPEND: begin
						if (stat.full) begin
							cmd.st_we = 1'b1;
							cmd.st    = ST_FULL;
						end else begin
							cmd.op = OP_APPEND;
							nxt    = S_SCAN;
						end
					end
					CMD_INSERT: begin
						if (stat.idx_gt) begin
							cmd.st_we = 1'b1;
							cmd.st    = ST_BADIDX;
						end else if (stat.full) begin
							cmd.st_we = 1'b1;
							cmd.st    = ST_FULL;
						end else begin
							cmd.op = OP_INS_INIT;
							nxt    = S_MOVE;
						end
					end
					CMD_DELETE: begin
						if (stat.idx_ge) begin
							cmd.st_we = 1'b1;
							cmd.st    = ST_BADIDX;
						end else begin
							cmd.op = OP_READ_IDX;
							nxt    = S_DEL;
						end
					end
					CMD_GET: begin
						if (stat.idx_ge) begin
							cmd.op    = OP_BADGET;
							cmd.st_we = 1'b1;
							cmd.st    = ST_BADIDX;
						end else begin
							cmd.op = OP_READ_IDX;
							nxt    = S_GET;
						end
					end
					CMD_SET: begin
						if (stat.idx_ge) begin
							cmd.st_we = 1'b1;
							cmd.st    = ST_BADIDX;
						end else begin
							cmd.op = OP_WRITE_IDX;
							nxt    = S_SCAN;
						end
					end
					CMD_SEARCH: begin
						cmd.op = OP_SRCH_INIT;
						nxt    = S_SRD;
					end
					CMD_MAX, CMD_MIN, CMD_AVG: begin
						if (stat.empty) begin
							cmd.st_we = 1'b1;
							cmd.st    = ST_EMPTY;
						end else begin
							cmd.op = OP_RED_INIT;
							nxt    = S_RED;
						end
					end
					CMD_SUM: begin
						cmd.op = OP_RED_INIT;
						nxt    = S_RED;
					end
					CMD_REVERSE: begin
						if (!stat.cnt_le1) begin
							cmd.op = OP_REV_INIT;
							nxt    = S_RRA;
						end
					end
					CMD_ROTL: begin
						if (!stat.cnt_le1) begin
							cmd.op = OP_READ0;
							nxt    = S_ROT;
						end
					end
					CMD_ROTR: begin
						if (!stat.cnt_le1) begin
							cmd.op = OP_READ_LAST;
							nxt    = S_ROT;
						end
					end
					CMD_SORTINS: begin
						if (!stat.sorted) begin
							cmd.st_we = 1'b1;
							cmd.st    = ST_UNSORTED;
						end else if (stat.full) begin
							cmd.st_we = 1'b1;
							cmd.st    = ST_FULL;
						end else begin
							cmd.op = OP_SI_INIT;
							nxt    = S_SIRD;
						end
					end
					default: nxt = S_FIN;
				endcase
			end
			// The cycle that sees the move count at zero also retires the last write.
			S_MOVE: begin
				if (stat.n_zero) begin
					nxt = S_MV_END;
				end else begin
					cmd.op = OP_MV_STEP;
				end
			end
			S_MV_END: begin
				nxt = S_SCAN;
				unique case (stat.cmd)
					CMD_INSERT: cmd.op = OP_PUT_IDX;
					CMD_DELETE: cmd.op = OP_DEL_FIN;
					CMD_ROTL:   cmd.op = OP_PUT_TMP_LAST;
					CMD_ROTR:   cmd.op = OP_PUT_TMP0;
					default:    cmd.op = OP_NOP;
				endcase
			end
			S_DEL: begin
				cmd.op = OP_DEL_CAP;
				nxt    = S_MOVE;
			end
			S_GET: begin
				cmd.op = OP_CAP_RES;
				nxt    = S_FIN;
			end
			S_ROT: begin
				cmd.op = OP_ROT_CAP;
				nxt    = S_MOVE;
			end
			S_SCAN: begin
				cmd.op = OP_RED_INIT;
				nxt    = S_RED;
			end
			S_RED: begin
				if (stat.n_zero) begin
					nxt = S_RED_END;
				end else begin
					cmd.op = OP_RED_STEP;
				end
			end
			S_RED_END: begin
				nxt = S_FIN;
				unique case (stat.cmd)
					CMD_MAX, CMD_MIN: cmd.op = OP_RES_BEST;
					CMD_SUM:          cmd.op = OP_RES_ACC;
					CMD_AVG: begin
						cmd.op = OP_DIV_START;
						nxt    = S_DIV;
					end
					default:          cmd.op = OP_SCAN_DONE;
				endcase
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.op = OP_RES_DIV;
					nxt    = S_FIN;
				end
			end
			S_SRD: begin
				if (!stat.p_lt_q) begin
					cmd.st_we = 1'b1;
					cmd.st    = ST_NOTFOUND;
					nxt       = S_FIN;
				end else begin
					cmd.op = OP_SRCH_RD;
					nxt    = S_SCMP;
				end
			end
			S_SCMP: begin
				if (stat.key_eq) begin
					cmd.op = OP_SRCH_HIT;
					nxt    = S_FIN;
				end else begin
					cmd.op = OP_SRCH_UPD;
					nxt    = S_SRD;
				end
			end
			S_RRA: begin
				if (stat.p_lt_q) begin
					cmd.op = OP_REV_RA;
					nxt    = S_RRB;
				end else begin
					nxt = S_SCAN;
				end
			end
			S_RRB: begin
				cmd.op = OP_REV_RB;
				nxt    = S_RWA;
			end
			S_RWA: begin
				cmd.op = OP_REV_WA;
				nxt    = S_RWB;
			end
			S_RWB: begin
				cmd.op = OP_REV_WB;
				nxt    = S_RRA;
			end
			S_SIRD: begin
				if (stat.p_zero) begin
					cmd.op = OP_SI_PUT;
					nxt    = S_FIN;
				end else begin
					cmd.op = OP_SI_RD;
					nxt    = S_SICMP;
				end
			end
			S_SICMP: begin
				if (stat.key_lt) begin
					cmd.op = OP_SI_SHIFT;
					nxt    = S_SIRD;
				end else begin
					cmd.op = OP_SI_PUT;
					nxt    = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.op = OP_FINISH;
					nxt    = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt;
		end
	end
endmodule

// ----- rtl/ale_dp.sv -----
// ----------------------------------------------------------------------------
// ale_dp
// Element memory, pointers, reduction unit and result register.
// ----------------------------------------------------------------------------
module ale_dp import ale_pkg::*; #(
	parameter int CAPACITY   = ALE_CAPACITY,
	parameter int ELEM_WIDTH = ALE_ELEM_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_item,
	input  logic      out_ready,
	output logic      out_valid,
	output out_item_t out_item,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat
);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = (CW > IDX_W) ? CW : IDX_W;

	logic signed [ELEM_WIDTH-1:0] mem [CAPACITY];

	cmd_t                    cmd_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [ELEM_WIDTH-1:0] val_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           p_q;
	logic [CW-1:0]           q_q;
	logic [CW-1:0]           n_q;
	logic [CW-1:0]           mid_q;
	logic                    dir_up_q;
	logic signed [ELEM_WIDTH-1:0] rd_q;
	logic signed [ELEM_WIDTH-1:0] tmp_q;
	logic signed [ELEM_WIDTH-1:0] best_q;
	logic signed [ELEM_WIDTH-1:0] prev_q;
	logic signed [RES_W-1:0] acc_q;
	logic                    first_q;
	logic                    scan_ok_q;
	logic                    red_v_s1;
	logic [AW-1:0]           wa_s1;
	logic                    v_s1;
	logic                    sorted_q;
	logic signed [RES_W-1:0] res_q;
	logic [POS_W-1:0]        pos_q;
	status_t                 st_q;
	logic                    neg_q;
	logic                    ov_q;
	out_item_t               out_q;

	logic [PW-1:0]           idx_ext;
	logic [PW-1:0]           cnt_ext;
	logic [CW-1:0]           count_m1;
	logic [CW:0]             mid_sum;
	logic [CW-1:0]           mid;
	logic [AW-1:0]           ra;
	logic                    we;
	logic [AW-1:0]           wa;
	logic signed [ELEM_WIDTH-1:0] wd;
	logic                    div_done;
	logic [RES_W-1:0]        div_quo;
	logic [RES_W-1:0]        acc_mag;
	logic                    better;

	assign idx_ext  = PW'(idx_q);
	assign cnt_ext  = PW'(count_q);
	assign count_m1 = count_q - CW'(1);
	// Midpoint of [lo, hi-1], with lo in p_q and the exclusive bound in q_q.
	assign mid_sum  = {1'b0, p_q} + {1'b0, q_q} - (CW + 1)'(1);
	assign mid      = mid_sum[CW:1];
	assign acc_mag  = acc_q[RES_W-1] ? RES_W'(-acc_q) : RES_W'(acc_q);
	assign better   = (cmd_q == CMD_MAX) ? (rd_q > best_q) : (rd_q < best_q);

	assign stat.cmd      = cmd_q;
	assign stat.idx_gt   = idx_ext > cnt_ext;
	assign stat.idx_ge   = idx_ext >= cnt_ext;
	assign stat.full     = count_q >= CW'(CAPACITY);
	assign stat.empty    = count_q == '0;
	assign stat.cnt_le1  = count_q <= CW'(1);
	assign stat.n_zero   = n_q == '0;
	assign stat.p_lt_q   = p_q < q_q;
	assign stat.p_zero   = p_q == '0;
	assign stat.key_eq   = rd_q == val_q;
	assign stat.key_lt   = val_q < rd_q;
	assign stat.sorted   = sorted_q;
	assign stat.out_free = !ov_q || out_ready;
	assign stat.div_done = div_done;

	ale_div #(
		.DW (RES_W),
		.VW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV_START),
		.dividend (acc_mag),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Memory port selection. A pending shift write owns the write port.
	always_comb begin
		ra = '0;
		we = 1'b0;
		wa = '0;
		wd = rd_q;
		if (v_s1) begin
			we = 1'b1;
			wa = wa_s1;
		end
		case (cmd.op)
			OP_APPEND: begin
				we = 1'b1;
				wa = count_q[AW-1:0];
				wd = val_q;
			end
			OP_WRITE_IDX, OP_PUT_IDX: begin
				we = 1'b1;
				wa = idx_ext[AW-1:0];
				wd = val_q;
			end
			OP_READ_IDX:  ra = idx_ext[AW-1:0];
			OP_READ0:     ra = '0;
			OP_READ_LAST: ra = count_m1[AW-1:0];
			OP_SRCH_RD:   ra = mid[AW-1:0];
			OP_RED_STEP, OP_MV_STEP, OP_REV_RA: ra = p_q[AW-1:0];
			OP_REV_RB:    ra = q_q[AW-1:0];
			OP_REV_WA: begin
				we = 1'b1;
				wa = p_q[AW-1:0];
			end
			OP_REV_WB: begin
				we = 1'b1;
				wa = q_q[AW-1:0];
				wd = tmp_q;
			end
			OP_PUT_TMP0: begin
				we = 1'b1;
				wa = '0;
				wd = tmp_q;
			end
			OP_PUT_TMP_LAST: begin
				we = 1'b1;
				wa = count_m1[AW-1:0];
				wd = tmp_q;
			end
			OP_SI_RD: ra = count_m1[AW-1:0] - count_q[AW-1:0] + p_q[AW-1:0];
			OP_SI_SHIFT: begin
				we = 1'b1;
				wa = p_q[AW-1:0];
			end
			OP_SI_PUT: begin
				we = 1'b1;
				wa = p_q[AW-1:0];
				wd = val_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sorted_q <= 1'b1;
			ov_q     <= 1'b0;
			v_s1     <= 1'b0;
			red_v_s1 <= 1'b0;
		end else begin
			v_s1     <= cmd.op == OP_MV_STEP;
			red_v_s1 <= cmd.op == OP_RED_STEP;
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			case (cmd.op)
				OP_APPEND, OP_PUT_IDX, OP_SI_PUT: count_q <= count_q + CW'(1);
				OP_DEL_FIN:   count_q  <= count_m1;
				OP_SCAN_DONE: sorted_q <= scan_ok_q;
				OP_FINISH:    ov_q     <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.st_we) begin
			st_q <= cmd.st;
		end
		// Reduction stage: consumes the element read in the cycle before.
		if (red_v_s1) begin
			first_q <= 1'b0;
			prev_q  <= rd_q;
			acc_q   <= acc_q + RES_W'(rd_q);
			if (first_q || better) begin
				best_q <= rd_q;
			end
			if (!first_q && (prev_q > rd_q)) begin
				scan_ok_q <= 1'b0;
			end
		end
		case (cmd.op)
			OP_LOAD: begin
				cmd_q <= cmd_t'(in_item.command);
				idx_q <= in_item.index;
				val_q <= ELEM_WIDTH'(in_item.value);
				res_q <= '0;
				pos_q <= '0;
				st_q  <= ST_OK;
			end
			OP_INS_INIT: begin
				p_q      <= count_m1;
				n_q      <= count_q - CW'(idx_ext);
				dir_up_q <= 1'b1;
			end
			OP_DEL_CAP: begin
				res_q    <= RES_W'(rd_q);
				p_q      <= CW'(idx_ext) + CW'(1);
				n_q      <= count_m1 - CW'(idx_ext);
				dir_up_q <= 1'b0;
			end
			OP_CAP_RES: res_q <= RES_W'(rd_q);
			OP_BADGET:  res_q <= '1;
			OP_ROT_CAP: begin
				tmp_q <= rd_q;
				n_q   <= count_m1;
				if (cmd_q == CMD_ROTL) begin
					p_q      <= CW'(1);
					dir_up_q <= 1'b0;
				end else begin
					p_q      <= count_q - CW'(2);
					dir_up_q <= 1'b1;
				end
			end
			OP_MV_STEP: begin
				wa_s1 <= dir_up_q ? p_q[AW-1:0] + AW'(1) : p_q[AW-1:0] - AW'(1);
				p_q   <= dir_up_q ? p_q - CW'(1) : p_q + CW'(1);
				n_q   <= n_q - CW'(1);
			end
			OP_SRCH_INIT: begin
				p_q <= '0;
				q_q <= count_q;
			end
			OP_SRCH_RD:  mid_q <= mid;
			OP_SRCH_HIT: pos_q <= POS_W'(mid_q);
			OP_SRCH_UPD: begin
				if (val_q < rd_q) begin
					q_q <= mid_q;
				end else begin
					p_q <= mid_q + CW'(1);
				end
			end
			OP_RED_INIT: begin
				p_q       <= '0;
				n_q       <= count_q;
				first_q   <= 1'b1;
				scan_ok_q <= 1'b1;
				acc_q     <= '0;
			end
			OP_RED_STEP: begin
				p_q <= p_q + CW'(1);
				n_q <= n_q - CW'(1);
			end
			OP_RES_BEST:  res_q <= RES_W'(best_q);
			OP_RES_ACC:   res_q <= acc_q;
			OP_DIV_START: neg_q <= acc_q[RES_W-1];
			OP_RES_DIV:   res_q <= neg_q ? RES_W'(-div_quo) : RES_W'(div_quo);
			OP_REV_INIT: begin
				p_q <= '0;
				q_q <= count_m1;
			end
			OP_REV_RB: tmp_q <= rd_q;
			OP_REV_WB: begin
				p_q <= p_q + CW'(1);
				q_q <= q_q - CW'(1);
			end
			OP_SI_INIT:  p_q <= count_q;
			OP_SI_SHIFT: p_q <= p_q - CW'(1);
			OP_FINISH: begin
				out_q.result_value  <= res_q;
				out_q.position      <= pos_q;
				out_q.status        <= st_q;
				out_q.element_count <= COUNT_W'(count_q);
				out_q.in_order      <= sorted_q;
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign out_item  = out_q;
endmodule

// ----- rtl/array_list_engine.sv -----
// Get and failed commands go straight to the response; append and set add a sortedness
// scan of the list. Insert, delete and rotate move one element per cycle through the element
// memory, reverse swaps elements pairwise, sorted insert shifts elements one at a time, search
// reads one element per probe, and max, min and sum scan the whole list; average adds a pass
// through the divider. One command at a time.
// Reset empties the list (count zero, list in order); memory contents are not cleared.
// ----------------------------------------------------------------------------
// array_list_engine
// Fixed-capacity ordered element store executing one list command per beat.
// ----------------------------------------------------------------------------
module array_list_engine import ale_pkg::*; #(
	parameter int CAPACITY   = ALE_CAPACITY,
	parameter int ELEM_WIDTH = ALE_ELEM_WIDTH
) (
	input logic       clk,
	input logic       arst_n,
	ale_chan_if.sink   req,
	ale_chan_if.source rsp
);
	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_item;

	ale_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ale_dp #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (req.data),
		.out_ready (rsp.ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cmd       (cmd),
		.stat      (stat)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;
	assign rsp.data  = out_item;
endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the array list engine. Commands go in through a
// valid/ready driver with random idle bursts, and a monitor compares each
// response beat with a prediction from a behavioral list model.
// ----------------------------------------------------------------------------
module testbench;
	import ale_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = ALE_CAPACITY;
	localparam longint LIMIT = 3000000;

	logic clk;
	logic arst_n;

	ale_chan_if #(.payload_t(in_item_t))  req ();
	ale_chan_if #(.payload_t(out_item_t)) rsp ();

	array_list_engine DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	// Model state of the list.
	logic signed [31:0] list_q[$];

	in_item_t  cmd_queue[$];
	out_item_t expected_rsp[$];
	int  errors;
	int  cmds_sent;
	int  rsps_seen;
	bit  calm;
	bit  req_taken;
	longint cycles;
	int  drv_idle;
	int  mon_stall;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit list_in_order();
		for (int i = 1; i < list_q.size(); i++)
			if (list_q[i-1] > list_q[i]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic out_item_t apply_command(in_item_t it);
		out_item_t r;
		int n;
		logic signed [39:0] acc;
		logic signed [31:0] t;
		int lo, hi, mid, k;
		r = '0;
		r.status = ST_OK;
		n = list_q.size();
		case (it.command)
			CMD_APPEND:
				if (n >= CAP) r.status = ST_FULL;
				else list_q.push_back(it.value);
			CMD_INSERT:
				if (it.index > n) r.status = ST_BADIDX;
				else if (n >= CAP) r.status = ST_FULL;
				else list_q.insert(it.index, it.value);
			CMD_DELETE:
				if (it.index >= n) r.status = ST_BADIDX;
				else begin
					r.result_value = 40'(list_q[it.index]);
					list_q.delete(it.index);
				end
			CMD_GET:
				if (it.index >= n) begin
					r.status = ST_BADIDX;
					r.result_value = -40'sd1;
				end else r.result_value = 40'(list_q[it.index]);
			CMD_SET:
				if (it.index >= n) r.status = ST_BADIDX;
				else list_q[it.index] = it.value;
			CMD_SEARCH: begin
				lo = 0;
				hi = n - 1;
				r.status = ST_NOTFOUND;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (list_q[mid] == it.value) begin
						r.position = mid[7:0];
						r.status = ST_OK;
						break;
					end
					if (it.value < list_q[mid]) hi = mid - 1;
					else lo = mid + 1;
				end
			end
			CMD_MAX, CMD_MIN:
				if (n == 0) r.status = ST_EMPTY;
				else begin
					t = list_q[0];
					foreach (list_q[i])
						if (it.command == CMD_MAX ? list_q[i] > t : list_q[i] < t) t = list_q[i];
					r.result_value = 40'(t);
				end
			CMD_SUM, CMD_AVG: begin
				acc = '0;
				foreach (list_q[i]) acc += 40'(list_q[i]);
				r.result_value = acc;
				if (it.command == CMD_AVG) begin
					if (n == 0) begin
						r.status = ST_EMPTY;
						r.result_value = '0;
					end else r.result_value = acc / 40'(n);
				end
			end
			CMD_REVERSE:
				list_q.reverse();
			CMD_ROTL:
				if (n > 1) list_q.push_back(list_q.pop_front());
			CMD_ROTR:
				if (n > 1) list_q.push_front(list_q.pop_back());
			CMD_SORTINS:
				if (!list_in_order()) r.status = ST_UNSORTED;
				else if (n >= CAP) r.status = ST_FULL;
				else begin
					k = n;
					while (k > 0 && list_q[k-1] > it.value) k--;
					list_q.insert(k, it.value);
				end
			default: ;
		endcase
		r.element_count = 9'(list_q.size());
		r.in_order = list_in_order();
		return r;
	endfunction

	function automatic in_item_t make_cmd(logic [3:0] c, int idx, logic [31:0] v);
		in_item_t it;
		it.command = c;
		it.index = 8'(idx);
		it.value = v;
		return it;
	endfunction

	function automatic logic [31:0] rand_value(bit narrow);
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			default: return narrow ? 32'($signed($urandom_range(0, 40)) - 20) : $urandom();
		endcase
	endfunction

	function automatic int rand_index(int n);
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
		return (n == 0) ? 0 : $urandom_range(0, n);
	endfunction

	// Stimulus: directed extremes, then random phases. The count shadow here only
	// steers index choices; prediction happens when the driver's beat is accepted.
	initial begin
		int n;
		logic [3:0] c;
		cmd_queue.push_back(make_cmd(CMD_MAX, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_MIN, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_AVG, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_SUM, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_SEARCH, 0, 5));
		cmd_queue.push_back(make_cmd(CMD_GET, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_DELETE, 255, 0));
		cmd_queue.push_back(make_cmd(CMD_REVERSE, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_ROTL, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_INSERT, 1, 3));
		cmd_queue.push_back(make_cmd(CMD_INSERT, 0, 32'h7fff_ffff));
		cmd_queue.push_back(make_cmd(CMD_APPEND, 0, 32'h8000_0000));
		cmd_queue.push_back(make_cmd(CMD_ROTR, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_CHECK, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_SORTINS, 0, 1));
		cmd_queue.push_back(make_cmd(CMD_ROTL, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_SORTINS, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_SEARCH, 0, 32'h8000_0000));
		cmd_queue.push_back(make_cmd(CMD_SET, 1, 32'hffff_ffff));
		cmd_queue.push_back(make_cmd(CMD_SUM, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_AVG, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_GET, 2, 0));
		cmd_queue.push_back(make_cmd(CMD_SET, 255, 0));
		cmd_queue.push_back(make_cmd(4'd15, 255, 32'hffff_ffff));
		n = 2;
		// Fill to capacity so that the full cases come up, then keep hammering.
		for (int i = 0; i < 260; i++) begin
			c = ($urandom_range(0, 1) == 0) ? 4'(CMD_APPEND) : 4'(CMD_INSERT);
			cmd_queue.push_back(make_cmd(c, rand_index(n), rand_value(1'b0)));
			if (n < CAP) n++;
		end
		cmd_queue.push_back(make_cmd(CMD_SUM, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_AVG, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_SORTINS, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_REVERSE, 0, 0));
		cmd_queue.push_back(make_cmd(CMD_MAX, 0, 0));
		// Drain to a small list.
		while (n > 4) begin
			cmd_queue.push_back(make_cmd(CMD_DELETE, $urandom_range(0, n - 1), 0));
			n--;
		end
		// Random phases on small lists: sorted-build phases and a mixed phase.
		for (int ph = 0; ph < 3; ph++) begin
			for (int i = 0; i < 75; i++) begin
				if (ph[0]) c = 4'($urandom_range(0, 15));
				else case ($urandom_range(0, 5))
					0, 1: c = CMD_SORTINS;
					2: c = CMD_SEARCH;
					3: c = CMD_DELETE;
					default: c = 4'($urandom_range(0, 15));
				endcase
				cmd_queue.push_back(make_cmd(c, rand_index(n), rand_value(1'b1)));
				case (c)
					CMD_APPEND, CMD_INSERT, CMD_SORTINS: if (n < 40) n++;
					CMD_DELETE: if (n > 0) n--;
					default: ;
				endcase
			end
			// Clear the list so the next sorted phase starts clean.
			for (int i = 0; i < 48; i++) cmd_queue.push_back(make_cmd(CMD_DELETE, 0, 0));
			n = 0;
		end
	end

	// Driver: changes on the falling edge. A beat is replaced only once the
	// preceding rising edge has taken it.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data  <= '0;
			drv_idle  <= 0;
		end else if (!req.valid || req_taken) begin
			if (drv_idle > 0) begin
				req.valid <= 1'b0;
				drv_idle  <= drv_idle - 1;
			end else if (cmd_queue.size() > 0) begin
				req.valid <= 1'b1;
				req.data  <= cmd_queue.pop_front();
				if (!calm && $urandom_range(0, 5) == 0) drv_idle <= $urandom_range(1, 3);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Receiver stall.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			mon_stall <= 0;
		end else if (mon_stall > 0) begin
			rsp.ready <= 1'b0;
			mon_stall <= mon_stall - 1;
		end else begin
			rsp.ready <= 1'b1;
			if (!calm && $urandom_range(0, 5) == 0) mon_stall <= $urandom_range(1, 3);
		end
	end

	// Monitor: accepted commands update the model, accepted responses are checked.
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		req_taken <= req.valid && req.ready;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (req.valid && req.ready) begin
				expected_rsp.push_back(apply_command(req.data));
				cmds_sent <= cmds_sent + 1;
			end
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				rsps_seen <= rsps_seen + 1;
				if (expected_rsp.size() == 0) begin
					$error("response beat with nothing expected");
					errors <= errors + 1;
				end else begin
					want = expected_rsp.pop_front();
					if (got.result_value !== want.result_value) begin
						$error("result_value: expected %0d, got %0d", want.result_value,
							got.result_value);
						errors <= errors + 1;
					end
					if (got.position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, got.position);
						errors <= errors + 1;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						errors <= errors + 1;
					end
					if (got.element_count !== want.element_count) begin
						$error("element_count: expected %0d, got %0d", want.element_count,
							got.element_count);
						errors <= errors + 1;
					end
					if (got.in_order !== want.in_order) begin
						$error("in_order: expected %0d, got %0d", want.in_order, got.in_order);
						errors <= errors + 1;
					end
				end
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		if (cycles >= LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cmds_sent = 0;
		rsps_seen = 0;
		cycles = 0;
		calm = 1'b0;
		req_taken = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (cmd_queue.size() < 150);
		calm = 1'b1;
		wait (cmd_queue.size() == 0 && !req.valid);
		wait (expected_rsp.size() == 0);
		repeat (600) @(posedge clk);
		$display("Ran %0d commands through the list engine, %0d responses checked,",
			cmds_sent, rsps_seen);
		$display("including a fill to capacity, drains and sorted-insert/search phases.");
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
